// File: rtl/first_fit_timed_allocator_macros.svh
// ----------------------------------------------------------------------------
// first_fit_timed_allocator assertion macros
// Clocked assertion wrappers used by the allocator module.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_TIMED_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_TIMED_ALLOCATOR_MACROS_SVH

// property sampled on clk, ignored while reset is asserted
`define FFTA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication form, antecedent and consequent in the same cycle
`define FFTA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/ffta_pkg.sv
// ----------------------------------------------------------------------------
// ffta_pkg
// Types, codes and helpers for the first-fit timed allocator.
// ----------------------------------------------------------------------------
package ffta_pkg;

	localparam int DEF_MAX_SEGMENTS = 64;
	localparam int DEF_MAX_WAITING  = 64;
	localparam logic [31:0] DEF_MEMORY_SIZE = 32'd1024;
	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	// result status codes
	localparam logic [1:0] STATUS_PLACED   = 2'd0;
	localparam logic [1:0] STATUS_QUEUED   = 2'd1;
	localparam logic [1:0] STATUS_DRAINED  = 2'd2;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DEL,
		ST_QCHK,
		ST_QRD,
		ST_PLACE,
		ST_LINK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] expiry;
		logic [31:0] length;
		logic [31:0] start;
	} seg_t;

	typedef struct packed {
		logic [31:0] duration;
		logic [31:0] length;
	} wait_t;

	// saturating 32-bit add
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? TIME_MAX : s[31:0];
	endfunction

endpackage

// File: rtl/first_fit_timed_allocator.sv
// Flow: each accepted item scans the list, then for an allocation a placement pass, then the
// output state; each release group adds a scan, an unlink pass and a queue check, and each
// queue retry a queue read and a placement pass; one item at a time, the result waits in the
// output register until taken and the sequencer returns to idle before the next item.
// The segment table and wait queue live in one-read one-write memories with registered reads.
// Reset (arst_n low) empties list, slot map and queue, clears time and count, sets size 1024.
// ----------------------------------------------------------------------------
// first_fit_timed_allocator
// First-fit contiguous allocator with timed release and a FIFO wait queue.
// ----------------------------------------------------------------------------
`include "first_fit_timed_allocator_macros.svh"

module first_fit_timed_allocator
	import ffta_pkg::*;
#(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
	parameter int MAX_WAITING  = DEF_MAX_WAITING
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // arrival_time, length, duration
	input  logic [0:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // placed_address, current_time, queued_total
	output logic [1:0]  m_tuser    // status
);

	localparam int IW = $clog2(MAX_SEGMENTS + 1);
	localparam int SW = $clog2(MAX_SEGMENTS);
	localparam int WW = (MAX_WAITING > 1) ? $clog2(MAX_WAITING) : 1;
	localparam int FW = $clog2(MAX_WAITING + 1);
	localparam logic [IW-1:0] NIL = IW'(MAX_SEGMENTS);
	localparam logic [WW-1:0] WLAST = WW'(MAX_WAITING - 1);
	localparam logic [FW:0] WDEPTH = (FW + 1)'(MAX_WAITING);

	// memories
	seg_t        seg_mem [MAX_SEGMENTS];
	logic [IW-1:0] link_mem [MAX_SEGMENTS];
	wait_t       wait_mem [MAX_WAITING];

	state_t state_q, state_d;
	logic [IW-1:0] cur_q, cur_d, prev_q, head_q, slot_q;
	seg_t seg_rd_q;
	logic [IW-1:0] link_rd_q;
	wait_t wait_rd_q;
	logic [MAX_SEGMENTS-1:0] used_q;
	logic [WW-1:0] whead_q;
	logic [FW-1:0] wfill_q;
	logic [31:0] time_q, qcount_q, size_q;
	logic drain_q, qmode_q, any_q;
	logic [31:0] arr_q, len_q, dur_q, plen_q, pend_q, group_q, addr_q;
	logic [32:0] gap_q;
	logic [1:0] status_q;
	logic m_tvalid_q;
	logic [95:0] m_tdata_q;
	logic [1:0] m_tuser_q;

	logic accept;
	logic [31:0] limit;
	logic [32:0] hi, gap_next;
	logic fit, free_any;
	logic [IW-1:0] free_slot;
	logic [FW:0] tail_sum;
	logic [WW-1:0] wtail;
	logic seg_we, link_we;
	logic [IW-1:0] seg_wa, link_wa, link_wd;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign limit    = drain_q ? TIME_MAX : arr_q;

	// gap check for the node in hand
	assign hi       = (cur_q == NIL) ? {1'b0, size_q} : {1'b0, seg_rd_q.start};
	assign fit      = (hi >= gap_q) && ((hi - gap_q) >= {1'b0, plen_q});
	assign gap_next = {1'b0, seg_rd_q.start} + {1'b0, seg_rd_q.length};

	// lowest free slot
	always_comb begin
		free_any  = 1'b0;
		free_slot = NIL;
		for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any  = 1'b1;
				free_slot = IW'(i);
			end
		end
	end

	// queue tail position
	always_comb begin
		tail_sum = {1'b0, FW'(whead_q)} + {1'b0, wfill_q};
		if (tail_sum >= WDEPTH) begin
			tail_sum = tail_sum - WDEPTH;
		end
		wtail = tail_sum[WW-1:0];
	end

	// next state, next node and memory writes
	always_comb begin
		state_d = state_q;
		cur_d   = cur_q;
		seg_we  = 1'b0;
		link_we = 1'b0;
		seg_wa  = free_slot;
		link_wa = free_slot;
		link_wd = cur_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cur_d   = head_q;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cur_q == NIL) begin
					cur_d   = head_q;
					state_d = any_q ? ST_DEL : (drain_q ? ST_OUT : ST_PLACE);
				end else begin
					cur_d = link_rd_q;
				end
			end
			ST_DEL: begin
				if (cur_q == NIL) begin
					state_d = ST_QCHK;
				end else begin
					cur_d = link_rd_q;
					if (seg_rd_q.expiry == group_q && prev_q != NIL) begin
						link_we = 1'b1;
						link_wa = prev_q;
						link_wd = link_rd_q;
					end
				end
			end
			ST_QCHK: begin
				cur_d   = head_q;
				state_d = (wfill_q == '0) ? ST_SCAN : ST_QRD;
			end
			ST_QRD: begin
				cur_d   = head_q;
				state_d = ST_PLACE;
			end
			ST_PLACE: begin
				if (fit) begin
					if (free_any) begin
						seg_we  = 1'b1;
						link_we = 1'b1;
						state_d = ST_LINK;
					end else begin
						cur_d   = head_q;
						state_d = qmode_q ? ST_SCAN : ST_OUT;
					end
				end else if (cur_q == NIL) begin
					cur_d   = head_q;
					state_d = qmode_q ? ST_SCAN : ST_OUT;
				end else begin
					cur_d = link_rd_q;
				end
			end
			ST_LINK: begin
				if (prev_q != NIL) begin
					link_we = 1'b1;
					link_wa = prev_q;
					link_wd = slot_q;
				end
				state_d = qmode_q ? ST_QCHK : ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// segment and link memories, registered read of the next node
	always_ff @(posedge clk) begin
		if (seg_we) begin
			seg_mem[seg_wa[SW-1:0]] <= '{expiry: pend_q, length: plen_q, start: gap_q[31:0]};
		end
		if (link_we) begin
			link_mem[link_wa[SW-1:0]] <= link_wd;
		end
		seg_rd_q  <= seg_mem[cur_d[SW-1:0]];
		link_rd_q <= link_mem[cur_d[SW-1:0]];
	end

	// wait queue memory, head entry always read
	always_ff @(posedge clk) begin
		if (state_q == ST_PLACE && !qmode_q && !fit && cur_q == NIL
			&& wfill_q != WDEPTH[FW-1:0]) begin
			wait_mem[wtail] <= '{duration: dur_q, length: len_q};
		end
		wait_rd_q <= wait_mem[whead_q];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state: list head, slot map, queue pointers, time, count, size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= NIL;
			used_q     <= '0;
			whead_q    <= '0;
			wfill_q    <= '0;
			time_q     <= '0;
			qcount_q   <= '0;
			size_q     <= DEF_MEMORY_SIZE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			// result valid: load in the output state, drop when taken
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_SCAN: begin
					if (cur_q == NIL && !any_q && !drain_q) begin
						time_q <= arr_q;
					end
				end
				ST_DEL: begin
					if (cur_q == NIL) begin
						time_q <= group_q;
					end else if (seg_rd_q.expiry == group_q) begin
						used_q[cur_q[SW-1:0]] <= 1'b0;
						if (prev_q == NIL) begin
							head_q <= link_rd_q;
						end
					end
				end
				ST_PLACE: begin
					if (fit && free_any) begin
						used_q[free_slot[SW-1:0]] <= 1'b1;
					end else if (!fit && cur_q == NIL && !qmode_q
						&& wfill_q != WDEPTH[FW-1:0]) begin
						wfill_q <= wfill_q + 1'b1;
						if (qcount_q != TIME_MAX) begin
							qcount_q <= qcount_q + 32'd1;
						end
					end
				end
				ST_LINK: begin
					if (prev_q == NIL) begin
						head_q <= slot_q;
					end
					if (qmode_q) begin
						whead_q <= (whead_q == WLAST) ? '0 : whead_q + 1'b1;
						wfill_q <= wfill_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					drain_q <= (s_tuser[0] == CMD_DRAIN);
					arr_q   <= s_tdata[31:0];
					len_q   <= s_tdata[63:32];
					dur_q   <= s_tdata[95:64];
					any_q   <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (cur_q == NIL) begin
					prev_q <= NIL;
					if (!any_q) begin
						status_q <= STATUS_DRAINED;
						addr_q   <= '0;
						plen_q   <= len_q;
						pend_q   <= sat_add(arr_q, dur_q);
						qmode_q  <= 1'b0;
						gap_q    <= '0;
					end
				end else if (seg_rd_q.expiry <= limit
					&& (!any_q || seg_rd_q.expiry < group_q)) begin
					group_q <= seg_rd_q.expiry;
					any_q   <= 1'b1;
				end
			end
			ST_DEL: begin
				if (cur_q != NIL && seg_rd_q.expiry != group_q) begin
					prev_q <= cur_q;
				end
			end
			ST_QCHK: begin
				any_q <= 1'b0;
			end
			ST_QRD: begin
				plen_q  <= wait_rd_q.length;
				pend_q  <= sat_add(time_q, wait_rd_q.duration);
				qmode_q <= 1'b1;
				gap_q   <= '0;
				prev_q  <= NIL;
			end
			ST_PLACE: begin
				if (fit && free_any) begin
					slot_q   <= free_slot;
					addr_q   <= gap_q[31:0];
					status_q <= STATUS_PLACED;
				end else if (fit || cur_q == NIL) begin
					any_q  <= 1'b0;
					addr_q <= '0;
					if (fit || wfill_q == WDEPTH[FW-1:0]) begin
						status_q <= STATUS_OVERFLOW;
					end else begin
						status_q <= STATUS_QUEUED;
					end
				end else begin
					gap_q  <= gap_next;
					prev_q <= cur_q;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {qcount_q, time_q, addr_q};
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`FFTA_ASSERT(a_fill_bound, wfill_q <= WDEPTH[FW-1:0], "wait queue fill beyond depth")
	`FFTA_ASSERT(a_accept_leaves_idle, accept |=> state_q != ST_IDLE, "accepted item did not start")
	`FFTA_ASSERT_IMPL(a_result_from_out, $rose(m_tvalid_q), $past(state_q) == ST_OUT,
		"result raised outside the output state")
	`FFTA_ASSERT_IMPL(a_link_slot_used, state_q == ST_LINK, used_q[slot_q[SW-1:0]],
		"linking a slot that is not marked used")

endmodule
